FILE: rtl/joystick_led_scroller_macros.svh
// ----------------------------------------------------------------------------
// Joystick LED scroller assertion macros
// Shared property shorthands for the scroller's checks.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_LED_SCROLLER_MACROS_SVH
`define JOYSTICK_LED_SCROLLER_MACROS_SVH

// Same-cycle implication.
`define JLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/jls_pkg.sv
// ----------------------------------------------------------------------------
// Joystick LED scroller package
// Types and constants shared by the scroller modules.
// ----------------------------------------------------------------------------
package jls_pkg;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WAIT  = 2'd1,
    PH_UP    = 2'd2,
    PH_DOWN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DIR_LEFT   = 2'd0,
    DIR_CENTRE = 2'd1,
    DIR_RIGHT  = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t       dir;
    logic [3:0] delay;
  } class_t;

  localparam logic [9:0] TH_L1 = 10'h072;
  localparam logic [9:0] TH_L2 = 10'h0E4;
  localparam logic [9:0] TH_L5 = 10'h156;
  localparam logic [9:0] TH_LA = 10'h1C8;
  localparam logic [9:0] TH_C  = 10'h238;
  localparam logic [9:0] TH_RA = 10'h2AA;
  localparam logic [9:0] TH_R5 = 10'h31C;
  localparam logic [9:0] TH_R2 = 10'h38E;

  localparam logic [3:0] DLY_0  = 4'd0;
  localparam logic [3:0] DLY_1  = 4'd1;
  localparam logic [3:0] DLY_2  = 4'd2;
  localparam logic [3:0] DLY_5  = 4'd5;
  localparam logic [3:0] DLY_10 = 4'd10;

  localparam logic [7:0] PATTERN_HIGH = 8'h80;
  localparam logic [7:0] PATTERN_LOW  = 8'h01;
  localparam logic [7:0] ROW_RESET    = 8'hFE;

endpackage

FILE: rtl/jls_classify.sv
// ----------------------------------------------------------------------------
// Joystick sample classifier
// Sorts a 10-bit sample into direction and shift delay.
// ----------------------------------------------------------------------------
module jls_classify (
  input  logic [9:0]      sample,
  output jls_pkg::class_t cls
);

  always_comb begin
    if (sample <= jls_pkg::TH_L1) begin
      cls = '{jls_pkg::DIR_LEFT, jls_pkg::DLY_1};
    end else if (sample <= jls_pkg::TH_L2) begin
      cls = '{jls_pkg::DIR_LEFT, jls_pkg::DLY_2};
    end else if (sample <= jls_pkg::TH_L5) begin
      cls = '{jls_pkg::DIR_LEFT, jls_pkg::DLY_5};
    end else if (sample <= jls_pkg::TH_LA) begin
      cls = '{jls_pkg::DIR_LEFT, jls_pkg::DLY_10};
    end else if (sample <= jls_pkg::TH_C) begin
      cls = '{jls_pkg::DIR_CENTRE, jls_pkg::DLY_0};
    end else if (sample <= jls_pkg::TH_RA) begin
      cls = '{jls_pkg::DIR_RIGHT, jls_pkg::DLY_10};
    end else if (sample <= jls_pkg::TH_R5) begin
      cls = '{jls_pkg::DIR_RIGHT, jls_pkg::DLY_5};
    end else if (sample <= jls_pkg::TH_R2) begin
      cls = '{jls_pkg::DIR_RIGHT, jls_pkg::DLY_2};
    end else begin
      cls = '{jls_pkg::DIR_RIGHT, jls_pkg::DLY_1};
    end
  end

endmodule

FILE: rtl/jls_mover.sv
// ----------------------------------------------------------------------------
// Joystick LED scroller phase machine
// Holds phase, tick counter and column pattern; steps once per word.
// ----------------------------------------------------------------------------
module jls_mover (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  jls_pkg::class_t cls,
  output logic [7:0]      pattern_next
);

`include "joystick_led_scroller_macros.svh"

  jls_pkg::phase_t phase;
  jls_pkg::phase_t phase_next;
  logic [3:0]      wait_count;
  logic [3:0]      wait_count_next;
  logic [7:0]      pattern_reg;

  always_comb begin
    case (phase)
      jls_pkg::PH_WAIT: begin
        case (cls.dir)
          jls_pkg::DIR_LEFT:  phase_next = jls_pkg::PH_DOWN;
          jls_pkg::DIR_RIGHT: phase_next = jls_pkg::PH_UP;
          default:            phase_next = jls_pkg::PH_WAIT;
        endcase
      end
      default: phase_next = jls_pkg::PH_WAIT;
    endcase
  end

  always_comb begin
    pattern_next    = pattern_reg;
    wait_count_next = wait_count;
    case (phase_next)
      jls_pkg::PH_UP: begin
        if (wait_count >= cls.delay) begin
          pattern_next    = (pattern_reg == jls_pkg::PATTERN_LOW) ?
                            jls_pkg::PATTERN_HIGH : (pattern_reg >> 1);
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_count + 4'd1;
        end
      end
      jls_pkg::PH_DOWN: begin
        if (wait_count >= cls.delay) begin
          pattern_next    = (pattern_reg == jls_pkg::PATTERN_HIGH) ?
                            jls_pkg::PATTERN_LOW : (pattern_reg << 1);
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_count + 4'd1;
        end
      end
      default: begin
        if (phase == jls_pkg::PH_WAIT) begin
          wait_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= jls_pkg::PH_START;
      wait_count  <= '0;
      pattern_reg <= jls_pkg::PATTERN_HIGH;
    end else if (step) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      pattern_reg <= pattern_next;
    end
  end

  `JLS_ASSERT_NOW(a_pattern_onehot, 1'b1, $onehot(pattern_reg), "column pattern not one-hot")
  `JLS_ASSERT_NOW(a_count_range, 1'b1, wait_count <= jls_pkg::DLY_10, "tick counter out of range")
  `JLS_ASSERT_NEXT(a_centre_holds, step && phase == jls_pkg::PH_WAIT && cls.dir == jls_pkg::DIR_CENTRE, phase == jls_pkg::PH_WAIT && wait_count == 4'd0, "centre did not hold wait")
  `JLS_ASSERT_NEXT(a_no_restart, step, phase != jls_pkg::PH_START, "returned to start phase")

endmodule

FILE: rtl/joystick_led_scroller.sv
// ----------------------------------------------------------------------------
// Joystick LED scroller
// Scrolls a one-hot column pattern left or right from joystick samples.
// ----------------------------------------------------------------------------
// Each accepted word is one tick with one joystick sample and gives exactly
// one result word. A sample passes an input register, then the classifier
// and phase update, and lands in the result register once the result
// register is free or its word is taken; a stall on out_ready holds it in
// the input register. One word is accepted per cycle while results are taken.
// The phase, tick counter and pattern update once per word, so the loop
// through that state is the single-cycle path that sets the rate.
// row_select is written through the cfg channel, resets to 0xFE, and is
// sampled into row_drive when a result is formed.
module joystick_led_scroller (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [9:0] stick_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] column_pattern,
  output logic [7:0] row_drive,
  output logic [1:0] direction,
  output logic [3:0] delay_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic            s1_valid;
  logic [9:0]      s1_sample;
  logic            advance;
  logic [7:0]      row_select;
  logic [7:0]      pattern_next;
  jls_pkg::class_t cls;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_select <= jls_pkg::ROW_RESET;
    end else if (cfg_valid) begin
      row_select <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= stick_sample;
    end
  end

  jls_classify u_classify (
    .sample (s1_sample),
    .cls    (cls)
  );

  jls_mover u_mover (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .cls          (cls),
    .pattern_next (pattern_next)
  );

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      column_pattern <= pattern_next;
      row_drive      <= row_select;
      direction      <= cls.dir;
      delay_code     <= cls.delay;
    end
  end

endmodule

FILE: tb/sv/tb_joystick_led_scroller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick LED scroller testbench
// Drives joystick ticks through the scroller and compares every result word
// with an in-bench scroll predictor: range edges, runs of one stick position,
// noise, row register settings, and back-to-back stretches with no stalls.
// ----------------------------------------------------------------------------
module tb_joystick_led_scroller;
  import jls_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_CAP    = 20;
  localparam int CENTRE_RANGE  = 4;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    dir_t       dir;
    logic [3:0] delay;
  } tick_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [9:0] stick_sample = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] column_pattern;
  logic [7:0] row_drive;
  logic [1:0] direction;
  logic [3:0] delay_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  bit idling = 1'b1;
  int mismatches = 0;
  int cycle_count = 0;
  int ticks_sent = 0;
  int ticks_checked = 0;
  int wraps = 0;
  int row_writes = 0;

  phase_t       scroll_phase = PH_START;
  logic [3:0]   tick_count = '0;
  logic [7:0]   column = PATTERN_HIGH;
  logic [7:0]   row_setting = ROW_RESET;
  tick_result_t expected_ticks[$];

  joystick_led_scroller dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stick_sample(stick_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .column_pattern(column_pattern),
    .row_drive(row_drive),
    .direction(direction),
    .delay_code(delay_code),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [9:0] range_top(input int r);
    case (r)
      0: return TH_L1;
      1: return TH_L2;
      2: return TH_L5;
      3: return TH_LA;
      4: return TH_C;
      5: return TH_RA;
      6: return TH_R5;
      7: return TH_R2;
      default: return 10'h3FF;
    endcase
  endfunction

  function automatic logic [9:0] sample_in(input int r);
    int base;
    base = (r == 0) ? 0 : int'(range_top(r - 1)) + 1;
    return 10'($urandom_range(base, int'(range_top(r))));
  endfunction

  function automatic tick_result_t sort_sample(input logic [9:0] s);
    tick_result_t t;
    t = '0;
    if (s > TH_LA && s <= TH_C) begin
      t.dir = DIR_CENTRE; t.delay = DLY_0;
    end else if (s <= TH_L1) begin
      t.dir = DIR_LEFT; t.delay = DLY_1;
    end else if (s <= TH_L2) begin
      t.dir = DIR_LEFT; t.delay = DLY_2;
    end else if (s <= TH_L5) begin
      t.dir = DIR_LEFT; t.delay = DLY_5;
    end else if (s <= TH_LA) begin
      t.dir = DIR_LEFT; t.delay = DLY_10;
    end else if (s <= TH_RA) begin
      t.dir = DIR_RIGHT; t.delay = DLY_10;
    end else if (s <= TH_R5) begin
      t.dir = DIR_RIGHT; t.delay = DLY_5;
    end else if (s <= TH_R2) begin
      t.dir = DIR_RIGHT; t.delay = DLY_2;
    end else begin
      t.dir = DIR_RIGHT; t.delay = DLY_1;
    end
    return t;
  endfunction

  function automatic void predict_tick(input logic [9:0] s);
    tick_result_t t;
    t = sort_sample(s);
    case (scroll_phase)
      PH_WAIT: begin
        if (t.dir == DIR_LEFT) scroll_phase = PH_DOWN;
        else if (t.dir == DIR_RIGHT) scroll_phase = PH_UP;
        else tick_count = '0;
      end
      default: scroll_phase = PH_WAIT;
    endcase
    if (scroll_phase == PH_UP || scroll_phase == PH_DOWN) begin
      if (tick_count >= t.delay) begin
        if (scroll_phase == PH_UP) begin
          if (column == PATTERN_LOW) wraps++;
          column = (column == PATTERN_LOW) ? PATTERN_HIGH : column >> 1;
        end else begin
          if (column == PATTERN_HIGH) wraps++;
          column = (column == PATTERN_HIGH) ? PATTERN_LOW : column << 1;
        end
        tick_count = '0;
      end else begin
        tick_count = tick_count + 4'd1;
      end
    end
    t.column = column;
    t.row = row_setting;
    expected_ticks.push_back(t);
    ticks_sent++;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch($sformatf("result word with none expected, column %h",
                                  column_pattern));
      end else begin
        want = expected_ticks.pop_front();
        ticks_checked++;
        if (column_pattern !== want.column)
          report_mismatch($sformatf("word %0d column_pattern %h, want %h",
                                    ticks_checked, column_pattern, want.column));
        if (row_drive !== want.row)
          report_mismatch($sformatf("word %0d row_drive %h, want %h",
                                    ticks_checked, row_drive, want.row));
        if (direction !== want.dir)
          report_mismatch($sformatf("word %0d direction %0d, want %0d",
                                    ticks_checked, direction, want.dir));
        if (delay_code !== want.delay)
          report_mismatch($sformatf("word %0d delay_code %0d, want %0d",
                                    ticks_checked, delay_code, want.delay));
      end
    end
  end

  always @(posedge clk)
    out_ready <= !(idling && $urandom_range(0, 99) < IDLE_PERCENT);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_tick(input logic [9:0] s);
    while (idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    stick_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(s);
  endtask

  task automatic wait_idle;
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row(input logic [7:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    row_setting = v;
    row_writes++;
  endtask

  // runs of one stick range so the counter reaches every delay and wraps
  task automatic send_runs(input int n);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 8);
      len = (r == CENTRE_RANGE) ? $urandom_range(1, 4) : $urandom_range(4, 40);
      for (int i = 0; i < len && sent < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_tick(10'($urandom_range(0, 1023)));
        else send_tick(sample_in(r));
        sent++;
      end
    end
  endtask

  task automatic test_range_edges;
    for (int r = 0; r < 9; r++) begin
      send_tick((r == 0) ? 10'h000 : range_top(r - 1) + 10'd1);
      send_tick(range_top(r));
    end
    wait_idle();
  endtask

  task automatic test_row_settings;
    logic [7:0] rows [4];
    rows[0] = 8'h00;
    rows[1] = 8'hFF;
    rows[2] = 8'($urandom_range(1, 254));
    rows[3] = ROW_RESET;
    for (int i = 0; i < 4; i++) begin
      write_row(rows[i]);
      send_runs(40);
    end
    wait_idle();
  endtask

  task automatic test_scroll_runs;
    send_runs(260);
    wait_idle();
  endtask

  task automatic test_noise;
    for (int i = 0; i < 100; i++) send_tick(10'($urandom_range(0, 1023)));
    wait_idle();
  endtask

  task automatic test_back_to_back;
    idling = 1'b0;
    send_runs(100);
    wait_idle();
    idling = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_range_edges();
    test_row_settings();
    test_scroll_runs();
    test_noise();
    test_back_to_back();
    $display("%0d ticks sent, %0d result words checked, %0d row writes",
             ticks_sent, ticks_checked, row_writes);
    $display("column pattern wrapped %0d times across left and right scrolls", wraps);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
